### rtl/dual_plane_vram_pixel_compositor_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-plane VRAM pixel compositor
// Shared concurrent assertion forms; each expects clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DUAL_PLANE_VRAM_PIXEL_COMPOSITOR_TOP_MACROS_SVH
`define DUAL_PLANE_VRAM_PIXEL_COMPOSITOR_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define DPVPC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dpvpc same-cycle check failed");

// antecedent implies consequent in the next cycle
`define DPVPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dpvpc next-cycle check failed");

`endif

### rtl/dpvpc_pkg.sv
// ----------------------------------------------------------------------------
// dpvpc_pkg
// Types and constants shared by the compositor front, queue and back end.
// ----------------------------------------------------------------------------
package dpvpc_pkg;

	// geometry
	localparam int unsigned POS_W       = 16;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam logic [7:0]  ROW_OFFSET  = 8'd10;

	// register reset values
	localparam logic [9:0]  WIDTH_RESET  = 10'd320;
	localparam logic [7:0]  HEIGHT_RESET = 8'd240;

	// register indexes
	localparam logic [1:0]  REG_SCREEN_WIDTH  = 2'd0;
	localparam logic [1:0]  REG_SCREEN_HEIGHT = 2'd1;

	// plane select codes
	localparam logic        PLANE_FRONT = 1'b0;
	localparam logic        PLANE_BACK  = 1'b1;

	// last address of the clearing sweep
	localparam logic [POS_W-1:0] CLEAR_LAST = {POS_W{1'b1}};

	// request word
	typedef struct packed {
		logic [16:0] word_address;
		logic [15:0] write_data;
		logic        write_upper;
		logic        write_lower;
	} req_word_t;

	// pixel-pair word
	typedef struct packed {
		logic [7:0] pixel_row;
		logic [7:0] pair_column;
		logic [8:0] left_pixel;
		logic [8:0] right_pixel;
	} pix_word_t;

	// classified command passed from front to back
	typedef struct packed {
		logic        plane;
		logic [7:0]  row_y;
		logic [7:0]  col_x;
		logic [15:0] data;
		logic        wr_hi;
		logic        wr_lo;
		logic        visible;
		logic [7:0]  pixel_row;
	} cmd_t;

endpackage

### rtl/dpvpc_front.sv
// ----------------------------------------------------------------------------
// dpvpc_front
// Holds the screen registers, accepts request words, drops writes with no
// lane enabled and tags each remaining write with its visibility.
// ----------------------------------------------------------------------------
module dpvpc_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [9:0]           cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  dpvpc_pkg::req_word_t req_word,
	input  logic                 clear_busy,
	input  logic                 queue_full,
	output logic                 push,
	output dpvpc_pkg::cmd_t      push_cmd
);

	logic [9:0] screen_width_q;
	logic [7:0] screen_height_q;
	logic [7:0] row_y;
	logic [7:0] col_x;
	logic       x_ok;
	logic       y_lo_ok;
	logic       y_hi_ok;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q  <= dpvpc_pkg::WIDTH_RESET;
			screen_height_q <= dpvpc_pkg::HEIGHT_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == dpvpc_pkg::REG_SCREEN_WIDTH) begin
				screen_width_q <= cfg_data;
			end else if (cfg_index == dpvpc_pkg::REG_SCREEN_HEIGHT) begin
				screen_height_q <= cfg_data[7:0];
			end
		end
	end

	// position and visibility
	assign col_x   = req_word.word_address[7:0];
	assign row_y   = req_word.word_address[15:8];
	assign x_ok    = {1'b0, col_x, 1'b0} < screen_width_q;
	assign y_lo_ok = row_y >= dpvpc_pkg::ROW_OFFSET;
	assign y_hi_ok = {1'b0, row_y} < ({1'b0, screen_height_q} + {1'b0, dpvpc_pkg::ROW_OFFSET});

	// accept once the RAM is cleared and while the queue has room
	assign req_ready = !clear_busy && !queue_full;
	assign push      = req_valid && req_ready && (req_word.write_upper || req_word.write_lower);

	always_comb begin
		push_cmd.plane     = req_word.word_address[16];
		push_cmd.row_y     = row_y;
		push_cmd.col_x     = col_x;
		push_cmd.data      = req_word.write_data;
		push_cmd.wr_hi     = req_word.write_upper;
		push_cmd.wr_lo     = req_word.write_lower;
		push_cmd.visible   = x_ok && y_lo_ok && y_hi_ok;
		push_cmd.pixel_row = row_y - dpvpc_pkg::ROW_OFFSET;
	end

endmodule

### rtl/dpvpc_queue.sv
// ----------------------------------------------------------------------------
// dpvpc_queue
// Short FIFO of classified commands between the front and the back end.
// ----------------------------------------------------------------------------
module dpvpc_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  dpvpc_pkg::cmd_t push_cmd,
	output logic            full,
	input  logic            pop,
	output logic            empty,
	output dpvpc_pkg::cmd_t head
);

	dpvpc_pkg::cmd_t                 entries_q [dpvpc_pkg::QUEUE_DEPTH];
	logic [dpvpc_pkg::QPTR_W-1:0]    wr_ptr_q;
	logic [dpvpc_pkg::QPTR_W-1:0]    rd_ptr_q;
	logic [dpvpc_pkg::QPTR_W:0]      count_q;

	assign full  = count_q == (dpvpc_pkg::QPTR_W + 1)'(dpvpc_pkg::QUEUE_DEPTH);
	assign empty = count_q == '0;
	assign head  = entries_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/dpvpc_back.sv
// ----------------------------------------------------------------------------
// dpvpc_back
// Owns the two RAM planes (split into byte lanes), clears them after reset,
// performs each write, reads both planes at the position and blends the pair.
// ----------------------------------------------------------------------------
`include "dual_plane_vram_pixel_compositor_top_macros.svh"

module dpvpc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 empty,
	input  dpvpc_pkg::cmd_t      head,
	output logic                 pop,
	output logic                 clear_busy,
	output logic                 pix_valid,
	input  logic                 pix_ready,
	output dpvpc_pkg::pix_word_t pix_word
);

	localparam int unsigned DEPTH = 2 ** dpvpc_pkg::POS_W;

	// byte-lane memories of each plane
	logic [7:0] front_hi_mem [DEPTH];
	logic [7:0] front_lo_mem [DEPTH];
	logic [7:0] back_hi_mem  [DEPTH];
	logic [7:0] back_lo_mem  [DEPTH];

	logic                       clr_busy_q;
	logic [dpvpc_pkg::POS_W-1:0] clr_cnt_q;
	logic [dpvpc_pkg::POS_W-1:0] mem_addr;
	logic [7:0]                 wr_hi_byte;
	logic [7:0]                 wr_lo_byte;
	logic                       we_front_hi;
	logic                       we_front_lo;
	logic                       we_back_hi;
	logic                       we_back_lo;

	logic                       s1_v_q;
	dpvpc_pkg::cmd_t            cmd_s1;
	logic [7:0]                 front_hi_s1;
	logic [7:0]                 front_lo_s1;
	logic [7:0]                 back_hi_s1;
	logic [7:0]                 back_lo_s1;
	logic                       advance;
	logic [7:0]                 fh;
	logic [7:0]                 fl;
	logic [7:0]                 bh;
	logic [7:0]                 bl;

	logic                       pix_valid_q;
	dpvpc_pkg::pix_word_t       pix_word_q;
	logic                       left_from_front;

	function automatic logic [8:0] blend_byte(input logic [7:0] front, input logic [7:0] back);
		if (front != 8'd0) begin
			return {1'b0, front};
		end
		return {1'b1, back};
	endfunction

	// clearing sweep after reset, both planes at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clr_busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == dpvpc_pkg::CLEAR_LAST) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	assign clear_busy = clr_busy_q;

	// issue control
	assign advance = s1_v_q && (!pix_valid_q || pix_ready);
	assign pop     = !clr_busy_q && !empty && (!s1_v_q || advance);

	// write port selection
	assign mem_addr    = clr_busy_q ? clr_cnt_q : {head.row_y, head.col_x};
	assign wr_hi_byte  = clr_busy_q ? 8'd0 : head.data[15:8];
	assign wr_lo_byte  = clr_busy_q ? 8'd0 : head.data[7:0];
	assign we_front_hi = clr_busy_q || (pop && head.plane == dpvpc_pkg::PLANE_FRONT && head.wr_hi);
	assign we_front_lo = clr_busy_q || (pop && head.plane == dpvpc_pkg::PLANE_FRONT && head.wr_lo);
	assign we_back_hi  = clr_busy_q || (pop && head.plane == dpvpc_pkg::PLANE_BACK && head.wr_hi);
	assign we_back_lo  = clr_busy_q || (pop && head.plane == dpvpc_pkg::PLANE_BACK && head.wr_lo);

	// memories: one write and one registered read per cycle each
	always_ff @(posedge clk) begin
		if (we_front_hi) begin
			front_hi_mem[mem_addr] <= wr_hi_byte;
		end
		if (pop) begin
			front_hi_s1 <= front_hi_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_front_lo) begin
			front_lo_mem[mem_addr] <= wr_lo_byte;
		end
		if (pop) begin
			front_lo_s1 <= front_lo_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_back_hi) begin
			back_hi_mem[mem_addr] <= wr_hi_byte;
		end
		if (pop) begin
			back_hi_s1 <= back_hi_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (we_back_lo) begin
			back_lo_mem[mem_addr] <= wr_lo_byte;
		end
		if (pop) begin
			back_lo_s1 <= back_lo_mem[mem_addr];
		end
	end

	// stage 1 command
	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= head;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (pop) begin
			s1_v_q <= 1'b1;
		end else if (advance) begin
			s1_v_q <= 1'b0;
		end
	end

	// read returned the old word; fold in this command's own lanes
	assign fh = (cmd_s1.plane == dpvpc_pkg::PLANE_FRONT && cmd_s1.wr_hi) ? cmd_s1.data[15:8]
		: front_hi_s1;
	assign fl = (cmd_s1.plane == dpvpc_pkg::PLANE_FRONT && cmd_s1.wr_lo) ? cmd_s1.data[7:0]
		: front_lo_s1;
	assign bh = (cmd_s1.plane == dpvpc_pkg::PLANE_BACK && cmd_s1.wr_hi) ? cmd_s1.data[15:8]
		: back_hi_s1;
	assign bl = (cmd_s1.plane == dpvpc_pkg::PLANE_BACK && cmd_s1.wr_lo) ? cmd_s1.data[7:0]
		: back_lo_s1;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= 1'b0;
		end else if (!pix_valid_q || pix_ready) begin
			pix_valid_q <= s1_v_q && cmd_s1.visible;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			pix_word_q.pixel_row   <= cmd_s1.pixel_row;
			pix_word_q.pair_column <= cmd_s1.col_x;
			pix_word_q.left_pixel  <= blend_byte(fh, bh);
			pix_word_q.right_pixel <= blend_byte(fl, bl);
		end
	end

	assign pix_valid = pix_valid_q;
	assign pix_word  = pix_word_q;

	// left pixel of a valid word taken from the front plane
	assign left_from_front = pix_valid_q && !pix_word_q.left_pixel[8];

	// checks
	`DPVPC_ASSERT_SAME(a_no_pop_while_clearing, clr_busy_q, !pop)
	`DPVPC_ASSERT_NEXT(a_visible_reaches_output, advance && cmd_s1.visible, pix_valid_q)
	`DPVPC_ASSERT_NEXT(a_clear_ends, clr_busy_q && clr_cnt_q == dpvpc_pkg::CLEAR_LAST, !clr_busy_q)
	`DPVPC_ASSERT_SAME(a_front_byte_nonzero, left_from_front, pix_word_q.left_pixel[7:0] != 8'd0)

endmodule

### rtl/dual_plane_vram_pixel_compositor_top.sv
// A taken request passes the queue, stage 1 and the output register; only a visible write
// gives a pixel-pair word. Throughput: one request per cycle while req_ready is high;
// each plane lane RAM does one write and one read a cycle. Reset: registers return to
// width 320, height 240; then a sweep zeroes both planes; req_ready is low until it ends.
// ----------------------------------------------------------------------------
// dual_plane_vram_pixel_compositor_top
// Two-plane video RAM with write-through compositing of the touched pixel pair.
// ----------------------------------------------------------------------------
module dual_plane_vram_pixel_compositor_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [9:0]           cfg_data,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  dpvpc_pkg::req_word_t req_word,
	output logic                 pix_valid,
	input  logic                 pix_ready,
	output dpvpc_pkg::pix_word_t pix_word
);

	logic            clear_busy;
	logic            queue_full;
	logic            queue_empty;
	logic            push;
	logic            pop;
	dpvpc_pkg::cmd_t push_cmd;
	dpvpc_pkg::cmd_t head;

	// front: registers and classification
	dpvpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_word   (req_word),
		.clear_busy (clear_busy),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// command queue
	dpvpc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (queue_full),
		.pop      (pop),
		.empty    (queue_empty),
		.head     (head)
	);

	// back: RAM planes and blend
	dpvpc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.empty      (queue_empty),
		.head       (head),
		.pop        (pop),
		.clear_busy (clear_busy),
		.pix_valid  (pix_valid),
		.pix_ready  (pix_ready),
		.pix_word   (pix_word)
	);

endmodule
